// ===== hw/rtl/ecal_pkg.sv =====
`timescale 1ns / 1ps

package ecal_pkg;

    // Field widths
    localparam int EPOCH_W  = 64;
    localparam int LIMIT_W  = 39;
    localparam int SPAN_W   = 39;
    localparam int DAYS_W   = 22;
    localparam int REM_W    = 17;
    localparam int R400_W   = 18;
    localparam int R100_W   = 16;
    localparam int R4_W     = 11;
    localparam int R3600_W  = 12;
    localparam int Q400_W   = 5;
    localparam int Q4_W     = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int DOM_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int WDAY_W   = 3;
    localparam int YDAY_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Pipeline depth: input register, three day-split stages, six calendar
    // stages and the result register.
    localparam int SPLIT_STAGES = 4;
    localparam int CAL_STAGES   = 7;
    localparam int STAGES       = SPLIT_STAGES + CAL_STAGES;

    // Calendar span 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
    localparam logic signed [LIMIT_W-1:0] SPAN_FIRST = -39'sd62135596800;
    localparam logic signed [LIMIT_W-1:0] SPAN_LAST  = 39'sd253402300799;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_WEEK = 7;
    localparam int DAYS_400Y     = 146097;
    localparam int DAYS_100Y     = 36524;
    localparam int DAYS_4Y       = 1461;
    localparam int DAYS_1Y       = 365;
    localparam int YEARS_400     = 400;
    localparam int YEARS_100     = 100;
    localparam int YEARS_4       = 4;
    localparam int LAST_CENTURY  = 3;
    localparam int LAST_QUAD     = 24;
    localparam int LAST_YEAR     = 3;

    // Seconds split: s / 86400 == (s >> 7) / 675
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = SECS_PER_DAY >> DAY_SHIFT;
    localparam int DAY_T_W   = SPAN_W - DAY_SHIFT;
    localparam int K_DAY     = 42;
    localparam logic [63:0] DAY_SCALE = 64'd1 << K_DAY;
    localparam int M_DAY_W   = 33;
    localparam logic [M_DAY_W-1:0] M_DAY = M_DAY_W'(DAY_SCALE / 64'(DAY_ODD));

    // Reciprocals, rounded down; each estimate is at most one low
    localparam int K_400   = DAYS_W;
    localparam int M_400   = (1 << K_400) / DAYS_400Y;
    localparam int M_400_W = $clog2(M_400 + 1);
    localparam int K_HOUR   = REM_W;
    localparam int M_HOUR   = (1 << K_HOUR) / SECS_PER_HOUR;
    localparam int M_HOUR_W = $clog2(M_HOUR + 1);
    localparam int K_MIN   = R3600_W;
    localparam int M_MIN   = (1 << K_MIN) / SECS_PER_MIN;
    localparam int M_MIN_W = $clog2(M_MIN + 1);
    localparam int K_4Y    = R100_W;
    localparam int M_4Y    = (1 << K_4Y) / DAYS_4Y;
    localparam int M_4Y_W  = $clog2(M_4Y + 1);

    localparam logic [YDAY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EPOCH_LOW  = 2'd0,
        REG_EPOCH_HIGH = 2'd1
    } t_cfg_reg;

    // Working set carried down the calendar stages
    typedef struct packed {
        logic                ok;
        logic [DAYS_W-1:0]   days;
        logic [REM_W-1:0]    rem;
        logic [Q400_W-1:0]   q400;
        logic [R400_W-1:0]   r400;
        logic [1:0]          q100;
        logic [R100_W-1:0]   r100;
        logic [Q4_W-1:0]     q4;
        logic [R4_W-1:0]     r4;
        logic [1:0]          q1;
        logic [HOUR_W-1:0]   hour;
        logic [R3600_W-1:0]  r3600;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
        logic [WDAY_W-1:0]   wday;
        logic [YDAY_W-1:0]   yday;
        logic [YEAR_W-1:0]   year;
        logic                leap;
    } t_work;

    typedef struct packed {
        logic                valid_res;
        logic [SEC_W-1:0]    second;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [DOM_W-1:0]    day_of_month;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [WDAY_W-1:0]   weekday;
        logic [YDAY_W-1:0]   day_of_year;
    } t_result;

endpackage

// ===== hw/rtl/ecal_ctrl.sv =====
`timescale 1ns / 1ps

module ecal_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_stall,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [ecal_pkg::STAGES-1:0]  o_en
);

    localparam int LAST = ecal_pkg::STAGES - 1;

    logic [ecal_pkg::STAGES-1:0] r_v;
    logic [ecal_pkg::STAGES-1:0] en;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        en[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // Advance the occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[LAST];
    assign o_en    = en;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted transfer did not load the input stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[0])
        else $error("input stalled while the input stage is empty");

    a_free_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while the output is free");
`endif

endmodule

// ===== hw/rtl/ecal_split.sv =====
`timescale 1ns / 1ps

module ecal_split (
    input  logic                                     i_clk,
    input  logic [ecal_pkg::SPLIT_STAGES-1:0]        i_en,
    input  logic signed [ecal_pkg::EPOCH_W-1:0]      i_epoch,
    input  logic signed [ecal_pkg::LIMIT_W-1:0]      i_lo,
    input  logic signed [ecal_pkg::LIMIT_W-1:0]      i_hi,
    output ecal_pkg::t_work                          o_w
);

    localparam int EXT_W  = ecal_pkg::EPOCH_W - ecal_pkg::LIMIT_W;
    localparam int PROD_W = ecal_pkg::DAY_T_W + ecal_pkg::M_DAY_W;
    localparam int DIFF_W = ecal_pkg::REM_W + 1;

    logic signed [ecal_pkg::EPOCH_W-1:0] r_epoch;
    logic                                r_ok1, r_ok2;
    logic [ecal_pkg::SPAN_W-1:0]         r_s1, r_s2;
    logic [ecal_pkg::DAYS_W-1:0]         r_qd2;
    ecal_pkg::t_work                     r_w3;

    logic signed [ecal_pkg::EPOCH_W-1:0] lo_ext, hi_ext;
    logic                                n_ok1;
    logic [ecal_pkg::SPAN_W-1:0]         n_s1;
    logic [PROD_W-1:0]                   day_prod;
    logic [ecal_pkg::DAYS_W-1:0]         n_qd2;
    logic [ecal_pkg::SPAN_W-1:0]         day_back, day_diff;
    logic [DIFF_W-1:0]                   rem_est;
    ecal_pkg::t_work                     n_w3;

    // Capture the epoch
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_epoch <= i_epoch;
        end
    end

    // Window check and offset from the start of the calendar
    assign lo_ext = $signed({{EXT_W{i_lo[ecal_pkg::LIMIT_W-1]}}, i_lo});
    assign hi_ext = $signed({{EXT_W{i_hi[ecal_pkg::LIMIT_W-1]}}, i_hi});
    assign n_ok1  = (r_epoch >= lo_ext) && (r_epoch <= hi_ext);
    assign n_s1   = r_epoch[ecal_pkg::SPAN_W-1:0] - $unsigned(ecal_pkg::SPAN_FIRST);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ok1 <= n_ok1;
            r_s1  <= n_s1;
        end
    end

    // Estimate the day count by reciprocal multiply
    assign day_prod = PROD_W'(r_s1[ecal_pkg::SPAN_W-1:ecal_pkg::DAY_SHIFT])
                    * PROD_W'(ecal_pkg::M_DAY);
    assign n_qd2    = day_prod[ecal_pkg::K_DAY +: ecal_pkg::DAYS_W];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ok2 <= r_ok1;
            r_s2  <= r_s1;
            r_qd2 <= n_qd2;
        end
    end

    // Correct the estimate and keep the seconds of the day
    assign day_back = ecal_pkg::SPAN_W'(r_qd2) * ecal_pkg::SPAN_W'(ecal_pkg::SECS_PER_DAY);
    assign day_diff = r_s2 - day_back;
    assign rem_est  = day_diff[DIFF_W-1:0];

    always_comb begin
        n_w3    = '0;
        n_w3.ok = r_ok2;
        if (rem_est >= DIFF_W'(ecal_pkg::SECS_PER_DAY)) begin
            n_w3.days = r_qd2 + 1'b1;
            n_w3.rem  = ecal_pkg::REM_W'(rem_est - DIFF_W'(ecal_pkg::SECS_PER_DAY));
        end else begin
            n_w3.days = r_qd2;
            n_w3.rem  = ecal_pkg::REM_W'(rem_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_w3 <= n_w3;
        end
    end

    assign o_w = r_w3;

endmodule

// ===== hw/rtl/ecal_cal.sv =====
`timescale 1ns / 1ps

module ecal_cal (
    input  logic                               i_clk,
    input  logic [ecal_pkg::CAL_STAGES-1:0]    i_en,
    input  ecal_pkg::t_work                    i_w,
    output ecal_pkg::t_result                  o_res
);

    localparam int P400_W  = ecal_pkg::DAYS_W + ecal_pkg::M_400_W;
    localparam int PHOUR_W = ecal_pkg::REM_W + ecal_pkg::M_HOUR_W;
    localparam int PMIN_W  = ecal_pkg::R3600_W + ecal_pkg::M_MIN_W;
    localparam int P4Y_W   = ecal_pkg::R100_W + ecal_pkg::M_4Y_W;
    localparam int D400_W  = ecal_pkg::DAYS_W + 1;
    localparam int SUM_W   = 6;
    localparam int FOLD_W  = 4;
    localparam int OCT_N   = (ecal_pkg::DAYS_W + 2) / 3;
    localparam int SECD_W  = ecal_pkg::SEC_W + 1;

    ecal_pkg::t_work   r_w4, r_w5, r_w6, r_w7, r_w8, r_w9;
    ecal_pkg::t_work   n_w4, n_w5, n_w6, n_w7, n_w8, n_w9;
    ecal_pkg::t_result r_res, n_res;

    logic [P400_W-1:0]             p400;
    logic [PHOUR_W-1:0]            phour;
    logic [3*OCT_N-1:0]            day1;
    logic [SUM_W-1:0]              oct_sum;
    logic [FOLD_W-1:0]             oct_fold;
    logic [D400_W-1:0]             d400;
    logic [ecal_pkg::REM_W-1:0]    dhour;
    logic [PMIN_W-1:0]             pmin;
    logic [P4Y_W-1:0]              p4y;
    logic [ecal_pkg::R3600_W-1:0]  dsec;
    logic [ecal_pkg::R100_W-1:0]   d4y;
    logic [ecal_pkg::YDAY_W-1:0]   thr [12];

    // Stage 4: quotient estimates for 400-year cycles and hours, weekday
    always_comb begin
        n_w4      = i_w;
        p400      = P400_W'(i_w.days) * P400_W'(ecal_pkg::M_400);
        n_w4.q400 = p400[ecal_pkg::K_400 +: ecal_pkg::Q400_W];
        phour     = PHOUR_W'(i_w.rem) * PHOUR_W'(ecal_pkg::M_HOUR);
        n_w4.hour = phour[ecal_pkg::K_HOUR +: ecal_pkg::HOUR_W];
        // 8 == 1 mod 7: sum octal digits, then fold
        day1      = (3*OCT_N)'(i_w.days) + 1'b1;
        oct_sum   = '0;
        for (int k = 0; k < OCT_N; k++) begin
            oct_sum = oct_sum + SUM_W'(day1[3*k +: 3]);
        end
        oct_fold  = FOLD_W'(oct_sum[5:3]) + FOLD_W'(oct_sum[2:0]);
        if (oct_fold >= FOLD_W'(2 * ecal_pkg::DAYS_PER_WEEK)) begin
            n_w4.wday = ecal_pkg::WDAY_W'(oct_fold - FOLD_W'(2 * ecal_pkg::DAYS_PER_WEEK));
        end else if (oct_fold >= FOLD_W'(ecal_pkg::DAYS_PER_WEEK)) begin
            n_w4.wday = ecal_pkg::WDAY_W'(oct_fold - FOLD_W'(ecal_pkg::DAYS_PER_WEEK));
        end else begin
            n_w4.wday = ecal_pkg::WDAY_W'(oct_fold);
        end
    end

    // Stage 5: correct 400-year cycle and hour, keep remainders
    always_comb begin
        n_w5 = r_w4;
        d400 = D400_W'(r_w4.days)
             - D400_W'(r_w4.q400) * D400_W'(ecal_pkg::DAYS_400Y);
        if (d400 >= D400_W'(ecal_pkg::DAYS_400Y)) begin
            n_w5.q400 = r_w4.q400 + 1'b1;
            n_w5.r400 = ecal_pkg::R400_W'(d400 - D400_W'(ecal_pkg::DAYS_400Y));
        end else begin
            n_w5.r400 = ecal_pkg::R400_W'(d400);
        end
        dhour = r_w4.rem
              - ecal_pkg::REM_W'(r_w4.hour) * ecal_pkg::REM_W'(ecal_pkg::SECS_PER_HOUR);
        if (dhour >= ecal_pkg::REM_W'(ecal_pkg::SECS_PER_HOUR)) begin
            n_w5.hour  = r_w4.hour + 1'b1;
            n_w5.r3600 = ecal_pkg::R3600_W'(dhour
                       - ecal_pkg::REM_W'(ecal_pkg::SECS_PER_HOUR));
        end else begin
            n_w5.r3600 = ecal_pkg::R3600_W'(dhour);
        end
    end

    // Stage 6: centuries (last one of the cycle is one day longer), minute estimate
    always_comb begin
        n_w6 = r_w5;
        if (r_w5.r400 >= ecal_pkg::R400_W'(3 * ecal_pkg::DAYS_100Y)) begin
            n_w6.q100 = 2'd3;
        end else if (r_w5.r400 >= ecal_pkg::R400_W'(2 * ecal_pkg::DAYS_100Y)) begin
            n_w6.q100 = 2'd2;
        end else if (r_w5.r400 >= ecal_pkg::R400_W'(ecal_pkg::DAYS_100Y)) begin
            n_w6.q100 = 2'd1;
        end else begin
            n_w6.q100 = 2'd0;
        end
        n_w6.r100   = ecal_pkg::R100_W'(r_w5.r400
                    - ecal_pkg::R400_W'(n_w6.q100) * ecal_pkg::R400_W'(ecal_pkg::DAYS_100Y));
        pmin        = PMIN_W'(r_w5.r3600) * PMIN_W'(ecal_pkg::M_MIN);
        n_w6.minute = pmin[ecal_pkg::K_MIN +: ecal_pkg::MIN_W];
    end

    // Stage 7: 4-year cycle estimate, correct minute and take seconds
    always_comb begin
        n_w7    = r_w6;
        p4y     = P4Y_W'(r_w6.r100) * P4Y_W'(ecal_pkg::M_4Y);
        n_w7.q4 = p4y[ecal_pkg::K_4Y +: ecal_pkg::Q4_W];
        dsec    = r_w6.r3600
                - ecal_pkg::R3600_W'(r_w6.minute) * ecal_pkg::R3600_W'(ecal_pkg::SECS_PER_MIN);
        if (dsec >= ecal_pkg::R3600_W'(ecal_pkg::SECS_PER_MIN)) begin
            n_w7.minute = r_w6.minute + 1'b1;
            n_w7.second = ecal_pkg::SEC_W'(SECD_W'(dsec)
                        - SECD_W'(ecal_pkg::SECS_PER_MIN));
        end else begin
            n_w7.second = ecal_pkg::SEC_W'(dsec);
        end
    end

    // Stage 8: correct 4-year cycle
    always_comb begin
        n_w8 = r_w7;
        d4y  = r_w7.r100
             - ecal_pkg::R100_W'(r_w7.q4) * ecal_pkg::R100_W'(ecal_pkg::DAYS_4Y);
        if (d4y >= ecal_pkg::R100_W'(ecal_pkg::DAYS_4Y)) begin
            n_w8.q4 = r_w7.q4 + 1'b1;
            n_w8.r4 = ecal_pkg::R4_W'(d4y - ecal_pkg::R100_W'(ecal_pkg::DAYS_4Y));
        end else begin
            n_w8.r4 = ecal_pkg::R4_W'(d4y);
        end
    end

    // Stage 9: single years (fourth one may run a day long), year and leap flag
    always_comb begin
        n_w9 = r_w8;
        if (r_w8.r4 >= ecal_pkg::R4_W'(3 * ecal_pkg::DAYS_1Y)) begin
            n_w9.q1 = 2'd3;
        end else if (r_w8.r4 >= ecal_pkg::R4_W'(2 * ecal_pkg::DAYS_1Y)) begin
            n_w9.q1 = 2'd2;
        end else if (r_w8.r4 >= ecal_pkg::R4_W'(ecal_pkg::DAYS_1Y)) begin
            n_w9.q1 = 2'd1;
        end else begin
            n_w9.q1 = 2'd0;
        end
        n_w9.yday = ecal_pkg::YDAY_W'(r_w8.r4
                  - ecal_pkg::R4_W'(n_w9.q1) * ecal_pkg::R4_W'(ecal_pkg::DAYS_1Y));
        n_w9.year = ecal_pkg::YEAR_W'(1)
                  + ecal_pkg::YEAR_W'(r_w8.q400) * ecal_pkg::YEAR_W'(ecal_pkg::YEARS_400)
                  + ecal_pkg::YEAR_W'(r_w8.q100) * ecal_pkg::YEAR_W'(ecal_pkg::YEARS_100)
                  + ecal_pkg::YEAR_W'(r_w8.q4) * ecal_pkg::YEAR_W'(ecal_pkg::YEARS_4)
                  + ecal_pkg::YEAR_W'(n_w9.q1);
        // Last year of a 4-year group leaps, except a century not closing a 400-year cycle
        n_w9.leap = (n_w9.q1 == 2'(ecal_pkg::LAST_YEAR))
                 && ((r_w8.q4 != ecal_pkg::Q4_W'(ecal_pkg::LAST_QUAD))
                  || (r_w8.q100 == 2'(ecal_pkg::LAST_CENTURY)));
    end

    // Stage 10: month, day of month; zero the result outside the window
    always_comb begin
        n_res = '0;
        for (int m = 0; m < 12; m++) begin
            thr[m] = ecal_pkg::MONTH_START[m]
                   + ecal_pkg::YDAY_W'((m >= 2 && r_w9.leap) ? 1 : 0);
        end
        for (int m = 1; m < 12; m++) begin
            if (r_w9.yday >= thr[m]) begin
                n_res.month = ecal_pkg::MONTH_W'(m);
            end
        end
        n_res.day_of_month = ecal_pkg::DOM_W'(r_w9.yday - thr[n_res.month] + 1'b1);
        n_res.valid_res    = r_w9.ok;
        n_res.second       = r_w9.second;
        n_res.minute       = r_w9.minute;
        n_res.hour         = r_w9.hour;
        n_res.year         = r_w9.year;
        n_res.weekday      = r_w9.wday;
        n_res.day_of_year  = r_w9.yday;
        if (!r_w9.ok) begin
            n_res = '0;
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_w4 <= n_w4;
        end
        if (i_en[1]) begin
            r_w5 <= n_w5;
        end
        if (i_en[2]) begin
            r_w6 <= n_w6;
        end
        if (i_en[3]) begin
            r_w7 <= n_w7;
        end
        if (i_en[4]) begin
            r_w8 <= n_w8;
        end
        if (i_en[5]) begin
            r_w9 <= n_w9;
        end
        if (i_en[6]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/epoch_to_utc_calendar.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     i_valid / o_stall        i_epoch_seconds
// result    o_valid / i_stall        o_valid_res, o_second .. o_day_of_year
// config    i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One epoch enters every cycle while o_stall is low; its result passes through
// 11 registers, input to result, before it is presented for transfer out.
// The depth is set by the chain of reciprocal multiplies and corrections
// (day split, 400/100/4/1-year cycles, hour/minute/second), spread over the stages.
// Each stage holds while the one below it is full and held, so the input
// stalls only when every stage is occupied and the result is stalled.
// Reset clears the occupancy bits and restores the window to the full span.

module epoch_to_utc_calendar (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [ecal_pkg::EPOCH_W-1:0]    i_epoch_seconds,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_valid_res,
    output logic [ecal_pkg::SEC_W-1:0]             o_second,
    output logic [ecal_pkg::MIN_W-1:0]             o_minute,
    output logic [ecal_pkg::HOUR_W-1:0]            o_hour,
    output logic [ecal_pkg::DOM_W-1:0]             o_day_of_month,
    output logic [ecal_pkg::MONTH_W-1:0]           o_month,
    output logic [ecal_pkg::YEAR_W-1:0]            o_year,
    output logic [ecal_pkg::WDAY_W-1:0]            o_weekday,
    output logic [ecal_pkg::YDAY_W-1:0]            o_day_of_year,
    input  logic                                   i_cfg_we,
    input  logic [ecal_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ecal_pkg::LIMIT_W-1:0]           i_cfg_data
);

    logic signed [ecal_pkg::LIMIT_W-1:0] r_lo, r_hi;
    logic signed [ecal_pkg::LIMIT_W-1:0] cfg_val;
    logic [ecal_pkg::STAGES-1:0]         en;
    ecal_pkg::t_work                     split_w;
    ecal_pkg::t_result                   res;

    // Store limits already clamped to the calendar span
    assign cfg_val = $signed(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= ecal_pkg::SPAN_FIRST;
            r_hi <= ecal_pkg::SPAN_LAST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecal_pkg::REG_EPOCH_LOW: begin
                    r_lo <= (cfg_val < ecal_pkg::SPAN_FIRST) ? ecal_pkg::SPAN_FIRST : cfg_val;
                end
                ecal_pkg::REG_EPOCH_HIGH: begin
                    r_hi <= (cfg_val > ecal_pkg::SPAN_LAST) ? ecal_pkg::SPAN_LAST : cfg_val;
                end
                default: begin
                end
            endcase
        end
    end

    ecal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_en    (en)
    );

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_en    (en[ecal_pkg::SPLIT_STAGES-1:0]),
        .i_epoch (i_epoch_seconds),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_w     (split_w)
    );

    ecal_cal u_cal (
        .i_clk (i_clk),
        .i_en  (en[ecal_pkg::STAGES-1:ecal_pkg::SPLIT_STAGES]),
        .i_w   (split_w),
        .o_res (res)
    );

    assign o_valid_res    = res.valid_res;
    assign o_second       = res.second;
    assign o_minute       = res.minute;
    assign o_hour         = res.hour;
    assign o_day_of_month = res.day_of_month;
    assign o_month        = res.month;
    assign o_year         = res.year;
    assign o_weekday      = res.weekday;
    assign o_day_of_year  = res.day_of_year;

endmodule
